FILE: rtl/rgme_pkg.sv
// Shared types and constants of the RGB gradient magnitude edge block.
// No dependencies; imported by rgme_front, rgme_back and the top level.
package rgme_pkg;

  // One RGB pixel, red in the lowest byte: [0] red, [1] green, [2] blue.
  typedef logic [2:0][7:0] pixel_t;

  // What the back end has to do with one queued pixel.
  typedef struct packed {
    logic emit_mid;   // a pixel of the row above is due
    logic interior;   // that pixel gets a gradient magnitude
    logic emit_cur;   // last row: the arriving pixel is due as well
  } item_flags_t;

  localparam int CFG_IDX_W = 2;
  localparam int DIM_REG_W = 11;
  localparam int COORD_W   = 10;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [DIM_REG_W-1:0] FRAME_DIM_RESET = 11'd1024;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Square root of dx*dx + dy*dy < 2^18: nine result bits, two radicand bits a step.
  localparam int RAD_W       = 18;
  localparam int ROOT_W      = 9;
  localparam int REM_W       = 11;
  localparam int SQRT_STEPS  = 9;
  localparam int STEP_W      = 4;
  localparam logic [7:0] SAT_MAX = 8'd255;

endpackage

FILE: rtl/rgme_front.sv
// Front end: configuration registers, raster position counters, pixel classification.
// Depends on rgme_pkg.
module rgme_front #(
  parameter int MAX_WIDTH  = rgme_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgme_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rgme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgme_pkg::DIM_REG_W-1:0]  cfg_data,
  input  logic                            pix_valid,
  output logic                            pix_ready,
  output logic                            push_valid,
  input  logic                            push_ready,
  output logic [$clog2(MAX_HEIGHT)-1:0]   push_row,
  output logic [$clog2(MAX_WIDTH)-1:0]    push_col,
  output rgme_pkg::item_flags_t           push_flags
);
  import rgme_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int WD_W  = COL_W + 1;
  localparam int HD_W  = ROW_W + 1;

  logic [DIM_REG_W-1:0] width_r, width_nxt, height_r, height_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [WD_W-1:0]      w_eff;
  logic [HD_W-1:0]      h_eff;
  logic                 last_col, last_row, accept;

  // Zero acts as one, anything above the maximum as the maximum.
  always_comb begin
    if (width_r == '0) begin
      w_eff = WD_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = WD_W'(MAX_WIDTH);
    end else begin
      w_eff = WD_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = HD_W'(1);
    end else if (int'(height_r) > MAX_HEIGHT) begin
      h_eff = HD_W'(MAX_HEIGHT);
    end else begin
      h_eff = HD_W'(height_r);
    end
  end

  assign cfg_ready  = 1'b1;
  assign pix_ready  = push_ready;
  assign push_valid = pix_valid;
  assign accept     = pix_valid && push_ready;

  assign last_col = ({1'b0, col_r} == w_eff - WD_W'(1));
  assign last_row = ({1'b0, row_r} == h_eff - HD_W'(1));

  assign push_row            = row_r;
  assign push_col            = col_r;
  assign push_flags.emit_mid = (row_r != '0);
  assign push_flags.interior = (row_r > ROW_W'(1)) && (col_r != '0) && !last_col;
  assign push_flags.emit_cur = last_row;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
    // A write to frame_width or frame_height restarts the frame.
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH: begin
          width_nxt = cfg_data;
          col_nxt   = '0;
          row_nxt   = '0;
        end
        REG_FRAME_HEIGHT: begin
          height_nxt = cfg_data;
          col_nxt    = '0;
          row_nxt    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FRAME_DIM_RESET;
      height_r <= FRAME_DIM_RESET;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

FILE: rtl/rgme_queue.sv
// Two-entry queue between front and back end.
// No dependencies.
module rgme_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  logic [DATA_W-1:0] wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output logic [DATA_W-1:0] rd_data
);
  logic [DATA_W-1:0] slot_r [2];
  logic              wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = slot_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: rtl/rgme_back.sv
// Back end: two line stores, per-channel squares and iterative square root, result register.
// Depends on rgme_pkg.
module rgme_back #(
  parameter int MAX_WIDTH  = rgme_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgme_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_valid,
  output logic                           q_ready,
  input  logic [$clog2(MAX_HEIGHT)-1:0]  q_row,
  input  logic [$clog2(MAX_WIDTH)-1:0]   q_col,
  input  rgme_pkg::item_flags_t          q_flags,
  input  rgme_pkg::pixel_t               q_pixel,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [rgme_pkg::COORD_W-1:0]   res_row,
  output logic [rgme_pkg::COORD_W-1:0]   res_col,
  output rgme_pkg::pixel_t               res_pixel,
  output logic                           res_last
);
  import rgme_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_WR       = 6'b000010,
    S_SQ0      = 6'b000100,
    S_SQRT     = 6'b001000,
    S_EMIT_MID = 6'b010000,
    S_EMIT_CUR = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  pixel_t older_mem [MAX_WIDTH];
  pixel_t prev_mem  [MAX_WIDTH];
  pixel_t older_rd_r, prev_rd_r;
  logic [COL_W-1:0] rd_addr;

  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  item_flags_t      flags_r;
  pixel_t           cur_r, up_r, mid_r, left_r;

  logic [RAD_W-1:0]  rad_r  [3];
  logic [REM_W-1:0]  rem_r  [3];
  logic [ROOT_W-1:0] root_r [3];
  logic [RAD_W-1:0]  rad_nxt  [3];
  logic [REM_W-1:0]  rem_nxt  [3];
  logic [ROOT_W-1:0] root_nxt [3];
  logic [STEP_W-1:0] step_r, step_nxt;

  logic               out_valid_r, out_last_r, out_free, out_load, out_last_nxt;
  logic [COORD_W-1:0] out_row_r, out_col_r, out_row_nxt;
  pixel_t             out_pix_r, out_pix_nxt, mid_res;

  logic [7:0]       dx, dy;
  logic [15:0]      dx2, dy2;
  logic [REM_W+1:0] shifted, trial;

  assign q_ready  = (state_r == S_IDLE);
  assign out_free = !out_valid_r || res_ready;

  always_comb begin
    unique case (state_r)
      S_IDLE:  rd_addr = q_col;
      S_WR:    rd_addr = col_r + COL_W'(1);
      default: rd_addr = col_r;
    endcase
  end

  // Line stores: rotate the row above into the older store while reading ahead.
  always_ff @(posedge clk) begin
    if (state_r == S_WR) begin
      older_mem[col_r] <= prev_rd_r;
      prev_mem[col_r]  <= cur_r;
    end
    older_rd_r <= older_mem[rd_addr];
    prev_rd_r  <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid) begin
      row_r   <= q_row;
      col_r   <= q_col;
      flags_r <= q_flags;
      cur_r   <= q_pixel;
    end
    if (state_r == S_WR) begin
      up_r   <= older_rd_r;
      mid_r  <= prev_rd_r;
      left_r <= mid_r;   // the previous pixel of the row above
    end
  end

  // Squares in S_SQ0 (right sample arrives from the read-ahead), one root digit per step after.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      rad_nxt[ch]  = rad_r[ch];
      rem_nxt[ch]  = rem_r[ch];
      root_nxt[ch] = root_r[ch];
    end
    step_nxt = step_r;
    dx = '0; dy = '0; dx2 = '0; dy2 = '0; shifted = '0; trial = '0;
    if (state_r == S_SQ0) begin
      for (int ch = 0; ch < 3; ch++) begin
        dx  = (prev_rd_r[ch] > left_r[ch]) ? prev_rd_r[ch] - left_r[ch]
                                            : left_r[ch] - prev_rd_r[ch];
        dy  = (cur_r[ch] > up_r[ch]) ? cur_r[ch] - up_r[ch] : up_r[ch] - cur_r[ch];
        dx2 = dx * dx;
        dy2 = dy * dy;
        rad_nxt[ch]  = RAD_W'(dx2) + RAD_W'(dy2);
        rem_nxt[ch]  = '0;
        root_nxt[ch] = '0;
      end
      step_nxt = STEP_W'(SQRT_STEPS - 1);
    end else if (state_r == S_SQRT) begin
      for (int ch = 0; ch < 3; ch++) begin
        shifted = {rem_r[ch], rad_r[ch][RAD_W-1 -: 2]};
        trial   = (REM_W+2)'({root_r[ch], 2'b01});
        if (shifted >= trial) begin
          rem_nxt[ch]  = REM_W'(shifted - trial);
          root_nxt[ch] = {root_r[ch][ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt[ch]  = REM_W'(shifted);
          root_nxt[ch] = {root_r[ch][ROOT_W-2:0], 1'b0};
        end
        rad_nxt[ch] = {rad_r[ch][RAD_W-3:0], 2'b00};
      end
      step_nxt = step_r - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      rad_r[ch]  <= rad_nxt[ch];
      rem_r[ch]  <= rem_nxt[ch];
      root_r[ch] <= root_nxt[ch];
    end
    step_r <= step_nxt;
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (root_r[ch] > ROOT_W'(SAT_MAX)) begin
        mid_res[ch] = SAT_MAX;
      end else begin
        mid_res[ch] = flags_r.interior ? root_r[ch][7:0] : mid_r[ch];
      end
      if (!flags_r.interior) begin
        mid_res[ch] = mid_r[ch];
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    out_load     = 1'b0;
    out_row_nxt  = COORD_W'(row_r);
    out_pix_nxt  = cur_r;
    out_last_nxt = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid) state_nxt = S_WR;
      end
      S_WR: begin
        if (flags_r.interior)      state_nxt = S_SQ0;
        else if (flags_r.emit_mid) state_nxt = S_EMIT_MID;
        else if (flags_r.emit_cur) state_nxt = S_EMIT_CUR;
        else                       state_nxt = S_IDLE;
      end
      S_SQ0: begin
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (step_r == '0) state_nxt = S_EMIT_MID;
      end
      S_EMIT_MID: begin
        out_row_nxt  = COORD_W'(row_r - ROW_W'(1));
        out_pix_nxt  = mid_res;
        out_last_nxt = !flags_r.emit_cur;
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = flags_r.emit_cur ? S_EMIT_CUR : S_IDLE;
        end
      end
      S_EMIT_CUR: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_row_r  <= out_row_nxt;
      out_col_r  <= COORD_W'(col_r);
      out_pix_r  <= out_pix_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_load || (out_valid_r && !res_ready);
    end
  end

  assign res_valid = out_valid_r;
  assign res_row   = out_row_r;
  assign res_col   = out_col_r;
  assign res_pixel = out_pix_r;
  assign res_last  = out_last_r;

`ifndef SYNTHESIS
  a_interior_row: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQ0 |-> row_r > ROW_W'(1))
    else $error("gradient computed for a pixel of the first two rows");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SQRT && step_r == '0 |=>
      root_r[0] < ROOT_W'(361) && root_r[1] < ROOT_W'(361) && root_r[2] < ROOT_W'(361))
    else $error("square root beyond the largest gradient");

  a_pending_cur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_last_r |-> state_r == S_EMIT_CUR)
    else $error("non-final result shown without the direct pixel pending");
`endif

endmodule

FILE: rtl/rgb_gradient_magnitude_edge.sv
// Top level of the RGB gradient magnitude edge block.
// Depends on rgme_pkg, rgme_front, rgme_queue and rgme_back.

// Takes RGB pixels in raster order and returns, one row late, each pixel of the row above with
// its coordinates: on the border (first/last row or column) the pixel unchanged, inside the
// frame per channel floor(sqrt(dx*dx + dy*dy)) saturated to 255, with dx the horizontal and dy
// the vertical central difference. Pixels of the first row give no result; pixels of the last
// row also come out themselves, right after the delayed pixel, and carry tlast; otherwise the
// single result of a pixel carries tlast. A pixel is worked on by one shared unit at a time:
// a border pixel takes two line-store accesses and one output load (a pixel of the first row
// no output load), an interior pixel two line-store accesses, one squaring step, nine
// square-root digit steps and one output load; the direct pixel in the last row adds one more
// output load; a stalled output holds the unit. A two-entry queue lets the input take pixels
// while the back end works, and the output register lets the back end move on while a result
// waits. Writing frame_width (index 0) or frame_height (index 1) restarts the frame; width or
// height 0 acts as 1, values above MAX_WIDTH / MAX_HEIGHT act as that maximum. Configure only
// while the block is idle.
module rgb_gradient_magnitude_edge #(
  parameter int MAX_WIDTH  = rgme_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = rgme_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // pixel_red, pixel_green, pixel_blue
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_row, out_column, edge_red, edge_green, edge_blue, 4 zero bits
  output logic [47:0]                     out_tdata,
  output logic                            out_tlast,  // run_last
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rgme_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgme_pkg::DIM_REG_W-1:0]  cfg_data
);
  import rgme_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam int ITEM_W = ROW_W + COL_W + $bits(item_flags_t) + $bits(pixel_t);

  logic                 push_valid, push_ready, q_valid, q_ready;
  logic [ROW_W-1:0]     push_row, q_row;
  logic [COL_W-1:0]     push_col, q_col;
  item_flags_t          push_flags, q_flags;
  pixel_t               q_pixel, res_pixel;
  logic [ITEM_W-1:0]    q_item;
  logic [COORD_W-1:0]   res_row, res_col;

  // Classify the arriving pixel against the current raster position.
  rgme_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_valid  (in_tvalid),
    .pix_ready  (in_tready),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_row   (push_row),
    .push_col   (push_col),
    .push_flags (push_flags)
  );

  // Hold up to two classified pixels for the back end.
  rgme_queue #(
    .DATA_W (ITEM_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  ({push_row, push_col, push_flags, in_tdata}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_item)
  );

  assign {q_row, q_col, q_flags, q_pixel} = q_item;

  // Line stores, gradient arithmetic and the result register.
  rgme_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_row     (q_row),
    .q_col     (q_col),
    .q_flags   (q_flags),
    .q_pixel   (q_pixel),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_row   (res_row),
    .res_col   (res_col),
    .res_pixel (res_pixel),
    .res_last  (out_tlast)
  );

  assign out_tdata = {4'b0000, res_pixel, res_col, res_row};

endmodule
